// ===== design/tspap_pkg.sv =====
// Shared types and constants of the TS packet aggregator and pacer.
// No dependencies; the interfaces, divider, multiplier and top level import it.
package tspap_pkg;

    localparam int TAG_W  = 8;
    localparam int TIME_W = 64;
    localparam int BASE_W = 33;
    localparam int EXT_W  = 9;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 2;

    localparam int TS_BYTES = 188;
    localparam logic [63:0] PCR_DIV = 64'd300;
    localparam logic [63:0] ALL_ONES = '1;

    // split by 300 as ((x >> 2) * PCR_RECIP) >> PCR_SHIFT, exact for 64-bit x
    localparam logic [63:0] PCR_RECIP = 64'd7870610804782742023;
    localparam int          PCR_SHIFT = 69;

    // mux modes
    localparam logic [1:0] MODE_VBR = 2'd0;
    localparam logic [1:0] MODE_CBR = 2'd1;
    localparam logic [1:0] MODE_CAP = 2'd2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_MODE = 2'd0;
    localparam logic [IDX_W-1:0] REG_MTU  = 2'd1;
    localparam logic [IDX_W-1:0] REG_RATE = 2'd2;
    localparam logic [IDX_W-1:0] REG_SI   = 2'd3;

    localparam logic [3:0] MTU_RESET = 4'd7;

    typedef struct packed {
        logic start;
        logic long_op;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

// ===== design/tspap_in_if.sv =====
// Input channel: one packet descriptor or flush command per item.
// Depends on tspap_pkg.
interface tspap_in_if;
    import tspap_pkg::*;
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [TAG_W-1:0]    packet_tag;
    logic                has_deadline;
    logic [TIME_W-1:0]   deadline;
    logic [TIME_W-1:0]   send_delay;
    logic                has_pcr;
    logic [TIME_W-1:0]   orig_sys_time;
    logic [TIME_W-1:0]   orig_prog_time;

    modport source (output valid, cmd, packet_tag, has_deadline, deadline, send_delay,
                    has_pcr, orig_sys_time, orig_prog_time, input ready);
    modport sink   (input valid, cmd, packet_tag, has_deadline, deadline, send_delay,
                    has_pcr, orig_sys_time, orig_prog_time, output ready);
endinterface

// ===== design/tspap_out_if.sv =====
// Output channel: one datagram slot per item.
// Depends on tspap_pkg.
interface tspap_out_if;
    import tspap_pkg::*;
    logic                valid;
    logic                ready;
    logic                slot_is_padding;
    logic [TAG_W-1:0]    out_tag;
    logic [TIME_W-1:0]   departure_time;
    logic                pcr_rewrite;
    logic [BASE_W-1:0]   pcr_base;
    logic [EXT_W-1:0]    pcr_ext;
    logic                last_slot;

    modport source (output valid, slot_is_padding, out_tag, departure_time, pcr_rewrite,
                    pcr_base, pcr_ext, last_slot, input ready);
    modport sink   (input valid, slot_is_padding, out_tag, departure_time, pcr_rewrite,
                    pcr_base, pcr_ext, last_slot, output ready);
endinterface

// ===== design/tspap_slot_mem.sv =====
// Slot store: one word per datagram slot (tag, PCR flag, clock data).
// One write port, one registered read port. No package dependency.
module tspap_slot_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int DW    = 137
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/tspap_div.sv =====
// Restoring divider, one quotient bit per cycle: 128 or 64 dividend bits.
// Depends on tspap_pkg (control and status structs).
module tspap_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tspap_pkg::t_div_ctl   i_ctl,
    input  logic [127:0]          i_num,
    input  logic [63:0]           i_den,
    output tspap_pkg::t_unit_sts  o_sts,
    output logic [127:0]          o_quo,
    output logic [63:0]           o_rem
);
    import tspap_pkg::*;

    logic         r_busy;
    logic         r_done;
    logic [6:0]   r_cnt;
    logic [127:0] r_nq;
    logic [63:0]  r_r;
    logic [63:0]  r_d;
    logic [64:0]  w_trial;
    logic         w_ge;
    logic [64:0]  w_diff;

    assign w_trial = {r_r, r_nq[127]};
    assign w_ge    = w_trial >= {1'b0, r_d};
    assign w_diff  = w_trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.long_op ? 7'd127 : 7'd63;
                r_nq   <= i_ctl.long_op ? i_num : {i_num[63:0], 64'b0};
                r_r    <= '0;
                r_d    <= i_den;
            end else if (r_busy) begin
                r_r  <= w_ge ? w_diff[63:0] : w_trial[63:0];
                r_nq <= {r_nq[126:0], w_ge};
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo = r_nq;
    assign o_rem = r_r;
endmodule

// ===== design/tspap_mul.sv =====
// Serial multiplier, 128 x 64 bits modulo 2^128, one 32x32 partial product a cycle.
// Depends on tspap_pkg (status struct).
module tspap_mul (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [127:0]          i_a,
    input  logic [63:0]           i_b,
    output tspap_pkg::t_unit_sts  o_sts,
    output logic [127:0]          o_prod
);
    import tspap_pkg::*;

    localparam logic [2:0] LAST_PP = 3'd6;

    logic         r_busy;
    logic         r_done;
    logic [2:0]   r_c;
    logic [127:0] r_a;
    logic [63:0]  r_b;
    logic         r_ppv;
    logic         r_plast;
    logic [63:0]  r_pp;
    logic [1:0]   r_pos;
    logic [127:0] r_acc;
    logic         w_j;
    logic [1:0]   w_i;
    logic [31:0]  w_al;
    logic [31:0]  w_bl;
    logic [127:0] w_term;

    // partial products with limb positions below 4: (0..3,0) then (0..2,1)
    assign w_j  = r_c >= 3'd4;
    assign w_i  = w_j ? 2'(r_c - 3'd4) : r_c[1:0];
    assign w_al = r_a[{w_i, 5'b0} +: 32];
    assign w_bl = r_b[{w_j, 5'b0} +: 32];

    always_comb begin
        case (r_pos)
            2'd0:    w_term = {64'b0, r_pp};
            2'd1:    w_term = {32'b0, r_pp, 32'b0};
            2'd2:    w_term = {r_pp, 64'b0};
            default: w_term = {r_pp[31:0], 96'b0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ppv  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_ppv  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_c    <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
            end else begin
                if (r_busy) begin
                    r_pp    <= 64'(w_al) * 64'(w_bl);
                    r_pos   <= 2'(w_i + 2'(w_j));
                    r_ppv   <= 1'b1;
                    r_plast <= r_c == LAST_PP;
                    r_c     <= r_c + 3'd1;
                    if (r_c == LAST_PP) begin
                        r_busy <= 1'b0;
                    end
                end
                if (r_ppv) begin
                    r_acc <= r_acc + w_term;
                    if (r_plast) begin
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_sts.busy = r_busy | r_ppv;
    assign o_sts.done = r_done;
    assign o_prod = r_acc;
endmodule

// ===== design/ts_packet_aggregator_pacer_top.sv =====
// Top level of the TS packet aggregator and pacer: sequencer, scalar state,
// slot store, divider and multiplier. Depends on tspap_pkg, the two channel
// interfaces, tspap_slot_mem, tspap_div and tspap_mul.
//
// Use: i_in carries one item per TS packet descriptor (cmd 0) or a flush
// (cmd 1). o_out carries one item per slot of each closed datagram, stored
// packets first, padding after, last_slot on the final one. Configuration
// is written through i_cfg_we / i_cfg_idx / i_cfg_data while the block idles.
// Items are processed one at a time; i_in.ready is high only when the
// sequencer is idle. Closing a datagram runs the 64-step rate division
// when the departure time advances, then reads each slot, with a reciprocal
// multiplication by 1/300 in the serial multiplier for a slot whose PCR is
// rewritten. A capped-mode schedule shift adds two serial multiplications
// and two 128-bit divisions. A new item is taken only once the previous
// one is through.
// Results leave through an output register, so a stalled receiver only
// holds the sequencer at the next slot; nothing is lost.
// Reset (synchronous, active low) empties the datagram, unsets the departure
// time, clears the remainder and restores the register defaults. The slot
// store is not cleared: only slots below the fill count are ever used.
module ts_packet_aggregator_pacer_top #(
    parameter int MAX_SLOTS = 8,
    parameter int TAG_BITS  = 8,
    parameter int CLOCK_HZ  = 27000000
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tspap_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [tspap_pkg::CFG_W-1:0]     i_cfg_data,
    tspap_in_if.sink                        i_in,
    tspap_out_if.source                     o_out
);
    import tspap_pkg::*;

    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam int DW = SW + 1 + 2 * TIME_W;
    localparam logic [63:0] STEP_UNIT = 64'(TS_BYTES) * 64'(CLOCK_HZ);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CHK    = 5'd1;
    localparam logic [4:0] S_LATE   = 5'd2;
    localparam logic [4:0] S_SH_D   = 5'd3;
    localparam logic [4:0] S_SH_M1  = 5'd4;
    localparam logic [4:0] S_SH_M1W = 5'd5;
    localparam logic [4:0] S_SH_V1  = 5'd6;
    localparam logic [4:0] S_SH_V1W = 5'd7;
    localparam logic [4:0] S_SH_M2  = 5'd8;
    localparam logic [4:0] S_SH_M2W = 5'd9;
    localparam logic [4:0] S_SH_V2  = 5'd10;
    localparam logic [4:0] S_SH_V2W = 5'd11;
    localparam logic [4:0] S_SH_CMP = 5'd12;
    localparam logic [4:0] S_CPL    = 5'd13;
    localparam logic [4:0] S_CPLW   = 5'd14;
    localparam logic [4:0] S_EMIT   = 5'd15;
    localparam logic [4:0] S_RD     = 5'd16;
    localparam logic [4:0] S_PCR    = 5'd17;
    localparam logic [4:0] S_PCRW   = 5'd18;
    localparam logic [4:0] S_OUT    = 5'd19;
    localparam logic [4:0] S_STORE  = 5'd20;
    localparam logic [4:0] S_FIN    = 5'd21;

    localparam logic RET_DONE  = 1'b0;
    localparam logic RET_STORE = 1'b1;

    // configuration
    logic [1:0]  r_mode;
    logic [3:0]  r_mtu;
    logic [31:0] r_rate;
    logic [31:0] r_si;
    logic [63:0] r_step;

    // scalar pacing state
    logic [CW-1:0] r_cnt;
    logic [63:0]   r_nd;
    logic [31:0]   r_rem;
    logic [63:0]   r_ed;

    // sequencer
    logic [4:0]    r_state;
    logic          r_ret;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_total;
    logic [63:0]   r_dep;
    logic [127:0]  r_x;
    logic [127:0]  r_k;
    logic [63:0]   r_t64;
    logic [31:0]   r_nrem;

    // latched item
    logic          r_hasdl;
    logic [63:0]   r_dts;
    logic [63:0]   r_delay;
    logic [63:0]   r_tgt;
    logic [7:0]    r_tag;
    logic          r_pcr;
    logic [63:0]   r_sys;
    logic [63:0]   r_prog;

    // output register
    logic          r_ovalid;
    logic          r_o_pad;
    logic [7:0]    r_o_tag;
    logic [63:0]   r_o_dep;
    logic          r_o_rw;
    logic [32:0]   r_o_base;
    logic [8:0]    r_o_ext;
    logic          r_o_last;
    logic [32:0]   r_base;
    logic [8:0]    r_ext;

    logic [CW-1:0] w_mtu_eff;
    logic [CW-1:0] w_total;
    logic          w_accept;
    logic          w_cpl_div;
    logic          w_real;
    logic          w_oload;
    logic          w_last;
    logic          w_pcr_div;
    logic [63:0]   w_prog_new;
    logic [127-PCR_SHIFT:0] w_pcr_q;
    logic [8:0]    w_pcr_qm;
    logic [8:0]    w_pcr_ext;

    logic [DW-1:0] w_rdata;
    logic [SW-1:0] w_rd_tag;
    logic          w_rd_pcr;
    logic [63:0]   w_rd_sys;
    logic [63:0]   w_rd_prog;

    t_div_ctl      w_div_ctl;
    t_unit_sts     w_div_sts;
    logic [127:0]  w_div_num;
    logic [63:0]   w_div_den;
    logic [127:0]  w_quo;
    logic [63:0]   w_drem;

    logic          w_mul_start;
    logic [127:0]  w_mul_a;
    logic [63:0]   w_mul_b;
    t_unit_sts     w_mul_sts;
    logic [127:0]  w_prod;

    // zero acts as one, values above the store depth act as the depth
    always_comb begin
        if (r_mtu == '0) begin
            w_mtu_eff = CW'(1);
        end else if (int'(r_mtu) > MAX_SLOTS) begin
            w_mtu_eff = CW'(MAX_SLOTS);
        end else begin
            w_mtu_eff = CW'(r_mtu);
        end
    end

    assign w_total  = (r_cnt > w_mtu_eff) ? r_cnt : w_mtu_eff;
    assign w_accept = i_in.valid && i_in.ready;
    assign w_cpl_div = (r_mode != MODE_VBR) && (r_nd != ALL_ONES) && (r_rate != '0);

    assign {w_rd_tag, w_rd_pcr, w_rd_sys, w_rd_prog} = w_rdata;
    assign w_real     = r_idx < r_cnt;
    assign w_pcr_div  = w_real && w_rd_pcr;
    assign w_prog_new = w_rd_prog + r_dep - w_rd_sys;
    assign w_oload    = (r_state == S_OUT) && (!r_ovalid || o_out.ready);
    assign w_last     = (r_idx + CW'(1)) == r_total;

    // PCR split: quotient from the reciprocal product, remainder from the low bits of the time
    assign w_pcr_q   = w_prod[127:PCR_SHIFT];
    assign w_pcr_qm  = w_pcr_q[8:0] * PCR_DIV[8:0];
    assign w_pcr_ext = w_prog_new[8:0] - w_pcr_qm;

    // launch of the shared units
    always_comb begin
        w_div_ctl.start   = 1'b0;
        w_div_ctl.long_op = 1'b1;
        w_div_num         = r_x;
        w_div_den         = r_step;
        case (r_state)
            S_SH_V1: begin
                w_div_ctl.start = 1'b1;
            end
            S_SH_V2: begin
                w_div_ctl.start = 1'b1;
                w_div_den       = 64'(r_rate);
            end
            S_CPL: begin
                w_div_ctl.start   = w_cpl_div;
                w_div_ctl.long_op = 1'b0;
                w_div_num         = {64'b0, r_step + 64'(r_rem)};
                w_div_den         = 64'(r_rate);
            end
            default: begin
                w_div_ctl.start = 1'b0;
            end
        endcase
    end

    assign w_mul_start = (r_state == S_SH_M1) || (r_state == S_SH_M2) ||
                         ((r_state == S_PCR) && w_pcr_div);

    always_comb begin
        case (r_state)
            S_SH_M1: begin
                w_mul_a = r_x;
                w_mul_b = 64'(r_rate);
            end
            S_PCR: begin
                w_mul_a = {66'b0, w_prog_new[63:2]};
                w_mul_b = PCR_RECIP;
            end
            default: begin
                w_mul_a = r_k;
                w_mul_b = r_step;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_step <= 64'(w_mtu_eff) * STEP_UNIT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_VBR;
            r_mtu    <= MTU_RESET;
            r_rate   <= '0;
            r_si     <= '0;
            r_cnt    <= '0;
            r_nd     <= ALL_ONES;
            r_rem    <= '0;
            r_ed     <= ALL_ONES;
            r_state  <= S_IDLE;
            r_ret    <= RET_DONE;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MODE: r_mode <= i_cfg_data[1:0];
                    REG_MTU:  r_mtu  <= i_cfg_data[3:0];
                    REG_RATE: begin
                        if (i_cfg_data != r_rate) begin
                            r_rem <= '0;
                        end
                        r_rate <= i_cfg_data;
                    end
                    REG_SI:   r_si <= i_cfg_data;
                    default:  r_si <= r_si;
                endcase
            end

            if (o_out.ready && !w_oload) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_hasdl <= i_in.has_deadline;
                        r_dts   <= i_in.has_deadline ? i_in.deadline : ALL_ONES;
                        r_delay <= i_in.send_delay;
                        r_tag   <= i_in.packet_tag;
                        r_pcr   <= i_in.has_pcr;
                        r_sys   <= i_in.orig_sys_time;
                        r_prog  <= i_in.orig_prog_time;
                        if (i_in.cmd) begin
                            r_ret   <= RET_DONE;
                            r_state <= S_CPL;
                        end else begin
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    // drop on zero rate or missing deadline outside VBR
                    if (r_mode != MODE_VBR && (r_rate == '0 || !r_hasdl)) begin
                        r_state <= S_IDLE;
                    end else begin
                        if (r_nd == ALL_ONES && r_dts != ALL_ONES) begin
                            r_nd <= r_dts - r_delay;
                        end
                        r_tgt   <= r_dts - r_delay;
                        r_state <= S_LATE;
                    end
                end
                S_LATE: begin
                    if (r_mode != MODE_VBR && r_nd > r_dts + 64'(r_si)) begin
                        r_state <= S_IDLE;
                    end else if (r_mode != MODE_VBR && r_tgt > r_nd + 64'(r_si)) begin
                        if (r_mode == MODE_CAP) begin
                            r_state <= S_SH_D;
                        end else begin
                            r_ret   <= RET_STORE;
                            r_state <= S_CPL;
                        end
                    end else begin
                        r_state <= S_STORE;
                    end
                end
                S_SH_D: begin
                    r_x     <= {64'b0, r_tgt - r_nd - 64'(r_si)};
                    r_state <= S_SH_M1;
                end
                S_SH_M1: r_state <= S_SH_M1W;
                S_SH_M1W: begin
                    if (w_mul_sts.done) begin
                        r_x     <= w_prod - 128'(r_rem);
                        r_state <= S_SH_V1;
                    end
                end
                S_SH_V1: r_state <= S_SH_V1W;
                S_SH_V1W: begin
                    if (w_div_sts.done) begin
                        // round the interval count up
                        r_k     <= w_quo + 128'(w_drem != '0);
                        r_state <= S_SH_M2;
                    end
                end
                S_SH_M2: r_state <= S_SH_M2W;
                S_SH_M2W: begin
                    if (w_mul_sts.done) begin
                        r_x     <= w_prod + 128'(r_rem);
                        r_state <= S_SH_V2;
                    end
                end
                S_SH_V2: r_state <= S_SH_V2W;
                S_SH_V2W: begin
                    if (w_div_sts.done) begin
                        r_t64   <= r_nd + w_quo[63:0];
                        r_nrem  <= w_drem[31:0];
                        r_state <= S_SH_CMP;
                    end
                end
                S_SH_CMP: begin
                    if (r_t64 > r_ed) begin
                        r_ret   <= RET_STORE;
                        r_state <= S_CPL;
                    end else begin
                        r_nd    <= r_t64;
                        r_rem   <= r_nrem;
                        r_state <= S_STORE;
                    end
                end
                S_CPL: begin
                    // capture the departure of the closing datagram, then advance it or, in VBR, unset it
                    r_dep   <= r_nd;
                    r_idx   <= '0;
                    r_total <= w_total;
                    if (r_mode == MODE_VBR) begin
                        r_nd    <= ALL_ONES;
                        r_state <= S_EMIT;
                    end else if (w_cpl_div) begin
                        r_state <= S_CPLW;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_CPLW: begin
                    if (w_div_sts.done) begin
                        r_nd    <= r_nd + w_quo[63:0];
                        r_rem   <= w_drem[31:0];
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (r_cnt == '0 && r_mode != MODE_CBR) begin
                        r_state <= (r_ret == RET_STORE) ? S_STORE : S_IDLE;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_PCR;
                S_PCR: begin
                    if (w_pcr_div) begin
                        r_state <= S_PCRW;
                    end else begin
                        r_base  <= '0;
                        r_ext   <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_PCRW: begin
                    if (w_mul_sts.done) begin
                        r_base  <= w_pcr_q[32:0];
                        r_ext   <= w_pcr_ext;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_oload) begin
                        r_ovalid <= 1'b1;
                        r_o_pad  <= !w_real;
                        r_o_tag  <= w_real ? 8'(w_rd_tag) : 8'd0;
                        r_o_dep  <= r_dep;
                        r_o_rw   <= w_pcr_div;
                        r_o_base <= r_base;
                        r_o_ext  <= r_ext;
                        r_o_last <= w_last;
                        r_idx    <= r_idx + CW'(1);
                        if (w_last) begin
                            r_cnt   <= '0;
                            r_ed    <= ALL_ONES;
                            r_state <= (r_ret == RET_STORE) ? S_STORE : S_IDLE;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_STORE: begin
                    if (r_dts < r_ed) begin
                        r_ed <= r_dts;
                    end
                    if (int'(r_cnt) < MAX_SLOTS) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // close once the datagram is full
                    if (r_cnt >= w_mtu_eff) begin
                        r_ret   <= RET_DONE;
                        r_state <= S_CPL;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    tspap_slot_mem #(
        .DEPTH (MAX_SLOTS),
        .AW    (IW),
        .DW    (DW)
    ) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_STORE) && (int'(r_cnt) < MAX_SLOTS)),
        .i_waddr (r_cnt[IW-1:0]),
        .i_wdata ({r_tag[SW-1:0], r_pcr, r_sys, r_prog}),
        .i_re    (r_state == S_RD),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (w_rdata)
    );

    tspap_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_sts   (w_div_sts),
        .o_quo   (w_quo),
        .o_rem   (w_drem)
    );

    tspap_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_sts   (w_mul_sts),
        .o_prod  (w_prod)
    );

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_ovalid;
    assign o_out.slot_is_padding = r_o_pad;
    assign o_out.out_tag         = r_o_tag;
    assign o_out.departure_time  = r_o_dep;
    assign o_out.pcr_rewrite     = r_o_rw;
    assign o_out.pcr_base        = r_o_base;
    assign o_out.pcr_ext         = r_o_ext;
    assign o_out.last_slot       = r_o_last;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cnt) <= MAX_SLOTS)
        else $error("slot count above store depth");

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("accepted item not processed");

    a_ed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_cnt == '0) |-> (r_ed == ALL_ONES))
        else $error("earliest deadline set on empty datagram");

    a_units_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_div_sts.busy && w_mul_sts.busy))
        else $error("divider and multiplier busy together");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_idx < r_total))
        else $error("slot index past datagram end");
`endif
endmodule

// ===== dv/tb_ts_packet_aggregator_pacer_top.sv =====
// Self-checking testbench for ts_packet_aggregator_pacer_top: directed and random
// descriptor streams against a cycle-free predictor of datagram slots.
// Depends on tspap_pkg, tspap_in_if, tspap_out_if and the design top level.
`timescale 1ns / 100ps

module tb_ts_packet_aggregator_pacer_top;
    import tspap_pkg::*;

    localparam int          SLOTS      = 8;
    localparam logic [63:0] TICKS_HZ   = 64'd27000000;
    localparam logic        CMD_PACKET = 1'b0;
    localparam logic        CMD_FLUSH  = 1'b1;
    localparam int          IDLE_LIMIT = 20000;
    localparam logic [3:0]  MODE_THREE = 4'd3;

    typedef struct {
        logic        cmd;
        logic [7:0]  tag;
        logic        has_dl;
        logic [63:0] deadline;
        logic [63:0] delay;
        logic        has_pcr;
        logic [63:0] orig_sys;
        logic [63:0] orig_prog;
    } t_desc;

    typedef struct {
        logic        pad;
        logic [7:0]  tag;
        logic [63:0] dep;
        logic        rw;
        logic [32:0] base;
        logic [8:0]  ext;
        logic        last;
    } t_slot;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_idx = REG_MODE;
    logic [CFG_W-1:0] i_cfg_data = '0;

    tspap_in_if  in_ch ();
    tspap_out_if out_ch ();

    ts_packet_aggregator_pacer_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #10 i_clk = ~i_clk;

    // Predictor state: register copies and datagram being filled.
    logic [1:0]  cfg_mode;
    logic [3:0]  cfg_mtu;
    logic [31:0] cfg_rate;
    logic [31:0] cfg_si;
    logic [7:0]  fill_tag [SLOTS];
    logic        fill_pcr [SLOTS];
    logic [63:0] fill_sys [SLOTS];
    logic [63:0] fill_prog [SLOTS];
    int          fill_cnt;
    logic [63:0] next_dep;
    logic [31:0] dep_rem;
    logic [63:0] earliest_dl;

    t_slot pending_slots[$];

    int   errors = 0;
    int   items_sent = 0;
    int   slots_seen = 0;
    int   pad_seen = 0;
    int   pcr_seen = 0;
    int   idle_cycles = 0;
    int   burst_left = 0;
    bit   gaps_on = 1'b1;
    bit   hold_req = 1'b0;
    logic [63:0] stream_now;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic logic [63:0] eff_mtu();
        if (cfg_mtu == 0) return 64'd1;
        if (cfg_mtu > SLOTS) return 64'(SLOTS);
        return {60'd0, cfg_mtu};
    endfunction

    function automatic logic [63:0] step_ticks();
        return eff_mtu() * TS_BYTES * TICKS_HZ;
    endfunction

    task automatic close_datagram();
        logic [63:0] dep;
        logic [63:0] num;
        logic [63:0] prog;
        logic [63:0] quo;
        int          total;
        t_slot       s;
        dep = next_dep;
        if (cfg_mode != MODE_VBR) begin
            if (next_dep != ALL_ONES && cfg_rate != 0) begin
                num = step_ticks() + {32'd0, dep_rem};
                next_dep = next_dep + num / {32'd0, cfg_rate};
                dep_rem = 32'(num % {32'd0, cfg_rate});
            end
        end else begin
            next_dep = ALL_ONES;
        end
        if (fill_cnt == 0 && cfg_mode != MODE_CBR) return;
        total = int'(eff_mtu());
        if (fill_cnt > total) total = fill_cnt;
        for (int i = 0; i < total; i++) begin
            s.dep  = dep;
            s.last = (i + 1 == total);
            if (i < fill_cnt) begin
                s.pad = 1'b0;
                s.tag = fill_tag[i];
                s.rw  = fill_pcr[i];
                s.base = '0;
                s.ext  = '0;
                if (fill_pcr[i]) begin
                    prog = fill_prog[i] + (dep - fill_sys[i]);
                    quo = prog / PCR_DIV;
                    s.base = quo[32:0];
                    s.ext  = 9'(prog % PCR_DIV);
                end
            end else begin
                s.pad = 1'b1;
                s.tag = '0;
                s.rw = 1'b0;
                s.base = '0;
                s.ext = '0;
            end
            pending_slots.push_back(s);
        end
        fill_cnt = 0;
        earliest_dl = ALL_ONES;
    endtask

    // Capped mode: move the schedule by whole intervals if the deadline allows.
    function automatic bit shift_schedule(logic [63:0] target);
        logic [127:0] a;
        logic [127:0] num;
        logic [127:0] k;
        logic [127:0] tot;
        logic [127:0] adv;
        logic [63:0]  d;
        logic [63:0]  nn;
        a = {64'd0, step_ticks()};
        d = target - (next_dep + {32'd0, cfg_si});
        num = {64'd0, d} * {96'd0, cfg_rate} - {96'd0, dep_rem};
        k = num / a;
        if (num % a != 0) k = k + 1;
        tot = k * a + {96'd0, dep_rem};
        adv = tot / {96'd0, cfg_rate};
        nn = next_dep + adv[63:0];
        if (nn > earliest_dl) return 1'b0;
        next_dep = nn;
        dep_rem = 32'(tot % {96'd0, cfg_rate});
        return 1'b1;
    endfunction

    task automatic pace_packet(t_desc it);
        logic [63:0] dts;
        logic [63:0] start;
        logic [63:0] lim;
        if (it.cmd == CMD_FLUSH) begin
            close_datagram();
            return;
        end
        if (cfg_mode != MODE_VBR && cfg_rate == 0) return;
        if (!it.has_dl && cfg_mode != MODE_VBR) return;
        dts = it.has_dl ? it.deadline : ALL_ONES;
        start = dts - it.delay;
        if (next_dep == ALL_ONES && dts != ALL_ONES) next_dep = start;
        lim = dts + {32'd0, cfg_si};
        if (cfg_mode != MODE_VBR && next_dep > lim) return;    // late: drop
        lim = next_dep + {32'd0, cfg_si};
        if (cfg_mode != MODE_VBR && start > lim) begin         // early
            if (cfg_mode != MODE_CAP || !shift_schedule(start)) close_datagram();
        end
        if (dts < earliest_dl) earliest_dl = dts;
        if (fill_cnt < SLOTS) begin
            fill_tag[fill_cnt]  = it.tag;
            fill_pcr[fill_cnt]  = it.has_pcr;
            fill_sys[fill_cnt]  = it.orig_sys;
            fill_prog[fill_cnt] = it.orig_prog;
            fill_cnt++;
        end
        if (64'(fill_cnt) + 1 > eff_mtu()) close_datagram();
    endtask

    // ---------------------------------------------------------------
    // Drivers, receiver, checker, watchdog
    // ---------------------------------------------------------------
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        case (idx)
            REG_MODE: cfg_mode = data[1:0];
            REG_MTU:  cfg_mtu = data[3:0];
            REG_RATE: begin
                if (data != cfg_rate) dep_rem = '0;
                cfg_rate = data;
            end
            REG_SI:   cfg_si = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_regs(logic [1:0] mode, logic [3:0] mtu, logic [31:0] rate,
                            logic [31:0] si);
        write_reg(REG_MODE, {30'd0, mode});
        write_reg(REG_MTU, {28'd0, mtu});
        write_reg(REG_RATE, rate);
        write_reg(REG_SI, si);
    endtask

    // Send one item; called and returns at a falling edge.
    task automatic send_item(t_desc it);
        if (burst_left == 0) begin
            in_ch.valid = 1'b0;
            if (gaps_on) repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        in_ch.valid          = 1'b1;
        in_ch.cmd            = it.cmd;
        in_ch.packet_tag     = it.tag;
        in_ch.has_deadline   = it.has_dl;
        in_ch.deadline       = it.deadline;
        in_ch.send_delay     = it.delay;
        in_ch.has_pcr        = it.has_pcr;
        in_ch.orig_sys_time  = it.orig_sys;
        in_ch.orig_prog_time = it.orig_prog;
        do @(posedge i_clk); while (!in_ch.ready);
        pace_packet(it);
        items_sent++;
        burst_left--;
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    // Wait until every predicted slot has left and the sequencer is idle.
    task automatic wait_idle();
        while (pending_slots.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Receiver: rotate through random stall styles; honor long hold-off requests.
    initial begin
        int hold_left;
        int phase_cnt;
        int style;
        hold_left = 0;
        phase_cnt = 0;
        style = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 400;
            end
            phase_cnt++;
            if (phase_cnt % 64 == 0) style = $urandom_range(0, 3);
            if (hold_left > 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else begin
                case (style)
                    0: out_ch.ready = 1'b1;
                    1: out_ch.ready = 1'($urandom_range(0, 1));
                    2: out_ch.ready = (phase_cnt % 5) != 0;
                    default: out_ch.ready = $urandom_range(0, 7) == 0;
                endcase
            end
        end
    end

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h, predicted %h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_slot e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_slots.size() == 0) begin
                report("unpredicted slot tag", 64'(out_ch.out_tag), 64'd0);
            end else begin
                e = pending_slots.pop_front();
                slots_seen++;
                if (e.pad) pad_seen++;
                if (e.rw) pcr_seen++;
                if (out_ch.slot_is_padding !== e.pad)
                    report("slot_is_padding", 64'(out_ch.slot_is_padding), 64'(e.pad));
                if (out_ch.out_tag !== e.tag)
                    report("out_tag", 64'(out_ch.out_tag), 64'(e.tag));
                if (out_ch.departure_time !== e.dep)
                    report("departure_time", out_ch.departure_time, e.dep);
                if (out_ch.pcr_rewrite !== e.rw)
                    report("pcr_rewrite", 64'(out_ch.pcr_rewrite), 64'(e.rw));
                if (out_ch.pcr_base !== e.base)
                    report("pcr_base", 64'(out_ch.pcr_base), 64'(e.base));
                if (out_ch.pcr_ext !== e.ext)
                    report("pcr_ext", 64'(out_ch.pcr_ext), 64'(e.ext));
                if (out_ch.last_slot !== e.last)
                    report("last_slot", 64'(out_ch.last_slot), 64'(e.last));
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Item builders
    // ---------------------------------------------------------------
    function automatic t_desc mk_pkt(logic [7:0] tag, logic has_dl, logic [63:0] dl,
                                     logic [63:0] delay, logic has_pcr,
                                     logic [63:0] sys, logic [63:0] prog);
        t_desc d;
        d.cmd = CMD_PACKET;
        d.tag = tag;
        d.has_dl = has_dl;
        d.deadline = dl;
        d.delay = delay;
        d.has_pcr = has_pcr;
        d.orig_sys = sys;
        d.orig_prog = prog;
        return d;
    endfunction

    function automatic t_desc mk_flush();
        t_desc d;
        d = mk_pkt('0, 1'b0, '0, '0, 1'b0, '0, '0);
        d.cmd = CMD_FLUSH;
        return d;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Ticks per TS packet at the current rate; a nominal value when rate is zero.
    function automatic logic [63:0] pkt_ticks();
        logic [63:0] p;
        p = (cfg_rate == 0) ? 64'd20000 : (64'd5076000000 / {32'd0, cfg_rate});
        if (p == 0) p = 1;
        if (p > 64'd100000000) p = 64'd100000000;
        return p;
    endfunction

    // Well-formed descriptor near the running stream time, with occasional
    // early or late deadlines.
    function automatic t_desc stream_pkt();
        logic [63:0] p;
        logic [63:0] dl;
        logic [63:0] delay;
        int          kind;
        p = pkt_ticks();
        stream_now = stream_now + p / 2 + 64'($urandom_range(0, int'(p * 3 / 2)));
        delay = 64'($urandom_range(0, int'(p * eff_mtu() * 3)));
        dl = stream_now + delay;
        kind = $urandom_range(0, 15);
        if (kind == 0) dl = dl + p * 40;                  // far early
        else if (kind == 1) dl = dl - p * 40;             // late
        return mk_pkt(8'($urandom), $urandom_range(0, 15) != 0, dl, delay,
                      1'($urandom_range(0, 1)),
                      stream_now - 64'($urandom_range(0, 5000)), rand64());
    endfunction

    function automatic t_desc noise_pkt();
        t_desc d;
        d = mk_pkt(8'($urandom), 1'($urandom), rand64(), rand64(), 1'($urandom),
                   rand64(), rand64());
        return d;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Reset defaults, variable rate: extreme times, undated packet, flush.
    task automatic test_vbr_defaults();
        send_item(mk_pkt(8'hFF, 1'b1, 64'd0, 64'd0, 1'b1, ALL_ONES, ALL_ONES));
        send_item(mk_pkt(8'h00, 1'b0, ALL_ONES, ALL_ONES, 1'b1, 64'd0, 64'd0));
        send_item(mk_pkt(8'hA5, 1'b1, ALL_ONES, 64'd12345, 1'b0, 64'd7, 64'd9));
        send_item(mk_flush());
        send_item(mk_flush());                          // empty: nothing
        wait_idle();
    endtask

    // Zero rate drops; flush with unset departure; mode three.
    task automatic test_zero_rate_and_unset();
        set_regs(MODE_CBR, 4'd3, 32'd0, 32'd1000);
        send_item(mk_pkt(8'h11, 1'b1, 64'd5000, 64'd10, 1'b0, 64'd0, 64'd0));
        send_item(mk_flush());                          // padding datagram, all ones
        wait_idle();
        write_reg(REG_RATE, 32'd1000000);
        send_item(mk_pkt(8'h12, 1'b0, 64'd5000, 64'd10, 1'b0, 64'd0, 64'd0)); // undated
        send_item(mk_pkt(8'h13, 1'b1, 64'd500000, 64'd100, 1'b1, 64'd400000, 64'd3));
        send_item(mk_flush());
        wait_idle();
        write_reg(REG_MODE, 32'(MODE_THREE));
        send_item(mk_flush());
        send_item(mk_pkt(8'h14, 1'b1, 64'd900000000, 64'd0, 1'b0, 64'd0, 64'd0));
        send_item(mk_flush());
        wait_idle();
    endtask

    // mtu of zero, above the slot count, and lowered under a filled datagram.
    task automatic test_mtu_limits();
        set_regs(MODE_VBR, 4'd0, 32'd0, 32'd0);
        send_item(mk_pkt(8'h21, 1'b1, 64'd100, 64'd1, 1'b1, 64'd50, 64'd1000));
        wait_idle();
        write_reg(REG_MTU, 32'd15);
        for (int i = 0; i < 8; i++)
            send_item(mk_pkt(8'(8'h30 + i), 1'b1, 64'(1000 + i), 64'd0, 1'b0, '0, '0));
        wait_idle();
        write_reg(REG_MTU, 32'd8);
        for (int i = 0; i < 5; i++)
            send_item(mk_pkt(8'(8'h40 + i), 1'b1, 64'(2000 + i), 64'd0, 1'b0, '0, '0));
        wait_idle();
        write_reg(REG_MTU, 32'd2);
        send_item(mk_pkt(8'h4F, 1'b1, 64'd3000, 64'd0, 1'b1, 64'd1, 64'd2));
        wait_idle();
    endtask

    // Capped mode: an early packet on an empty datagram shifts the schedule.
    task automatic test_capped_shift();
        set_regs(MODE_CAP, 4'd4, 32'd1000000, 32'd1000);
        send_item(mk_pkt(8'h51, 1'b1, 64'd1000000, 64'd0, 1'b0, '0, '0));
        send_item(mk_pkt(8'h52, 1'b1, 64'd900000000, 64'd0, 1'b0, '0, '0)); // early: close
        send_item(mk_flush());
        send_item(mk_pkt(8'h53, 1'b1, 64'd5000000000, 64'd0, 1'b1, 64'd1, 64'd1)); // shift
        send_item(mk_flush());
        wait_idle();
        set_regs(MODE_CBR, 4'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(mk_pkt(8'h54, 1'b1, ALL_ONES - 1, ALL_ONES, 1'b1, ALL_ONES, 64'd0));
        wait_idle();
    endtask

    // Receiver holds off while the sender keeps offering one-slot datagrams.
    task automatic test_backpressure();
        set_regs(MODE_VBR, 4'd1, 32'd0, 32'd0);
        gaps_on = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 20; i++)
            send_item(mk_pkt(8'($urandom), 1'b1, rand64(), rand64(), 1'($urandom),
                             rand64(), rand64()));
        gaps_on = 1'b1;
        wait_idle();
    endtask

    // Random phases through all modes and extreme register values.
    task automatic test_random_phases();
        logic [3:0]  mtu_pick [7] = '{4'd0, 4'd1, 4'd3, 4'd7, 4'd8, 4'd15, 4'd5};
        logic [31:0] rate;
        logic [31:0] si;
        int          r;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                3: rate = 32'hFFFF_FFFF;
                6: rate = 32'd0;
                default: rate = $urandom_range(200000, 20000000);
            endcase
            cfg_rate = cfg_rate;      // mirror stays until written below
            set_regs(2'(ph % 4), mtu_pick[ph % 7], rate, 32'd0);
            case (ph)
                1: si = 32'hFFFF_FFFF;
                2: si = 32'd0;
                default: si = 32'(pkt_ticks() * eff_mtu() * $urandom_range(0, 2));
            endcase
            write_reg(REG_SI, si);
            gaps_on = (ph % 3) != 2;
            stream_now = rand64() >> 2;
            for (int i = 0; i < 21; i++) begin
                r = $urandom_range(0, 19);
                if (r < 17) send_item(stream_pkt());
                else if (r < 19) send_item(noise_pkt());
                else send_item(mk_flush());
            end
            send_item(mk_flush());
            wait_idle();
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_PACKET;
        in_ch.packet_tag = '0;
        in_ch.has_deadline = 1'b0;
        in_ch.deadline = '0;
        in_ch.send_delay = '0;
        in_ch.has_pcr = 1'b0;
        in_ch.orig_sys_time = '0;
        in_ch.orig_prog_time = '0;
        cfg_mode = MODE_VBR;
        cfg_mtu = MTU_RESET;
        cfg_rate = '0;
        cfg_si = '0;
        fill_cnt = 0;
        next_dep = ALL_ONES;
        dep_rem = '0;
        earliest_dl = ALL_ONES;
        stream_now = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait_idle();

        test_vbr_defaults();
        test_zero_rate_and_unset();
        test_mtu_limits();
        test_capped_shift();
        test_backpressure();
        test_random_phases();

        while (pending_slots.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("Covered %0d input items and %0d datagram slots (%0d padding, %0d PCR).",
                 items_sent, slots_seen, pad_seen, pcr_seen);
        $display("Modes VBR/CBR/capped/undefined, mtu 0..15, rate and interval extremes.");
        if (errors == 0 && pending_slots.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== ts_packet_aggregator_pacer_top.f =====
design/tspap_pkg.sv
design/tspap_in_if.sv
design/tspap_out_if.sv
design/tspap_slot_mem.sv
design/tspap_div.sv
design/tspap_mul.sv
design/ts_packet_aggregator_pacer_top.sv
dv/tb_ts_packet_aggregator_pacer_top.sv
